// ----- hdl/tkh_pkg.sv -----
// tkh_pkg: shared types, codes and sizes for the top-k candidate heap
// no dependencies; used by tkh_engine, topk_candidate_heap and tkh_checker
package tkh_pkg;

    localparam int HEAP_DEPTH  = 64;
    localparam int MAX_RESULTS = 64;
    localparam int ADDR_W      = $clog2(HEAP_DEPTH);
    localparam int FILL_W      = $clog2(HEAP_DEPTH + 1);
    localparam int IDX_W       = ADDR_W + 2;
    localparam int CMP_W       = (FILL_W > 7) ? FILL_W : 7;
    localparam int CNT_W       = $clog2(MAX_RESULTS);

    typedef logic [63:0]       t_key;
    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [FILL_W-1:0] t_fill;

    typedef enum logic [1:0] {
        REQ_OFFER = 2'd0,
        REQ_DRAIN = 2'd1,
        REQ_CLEAR = 2'd2
    } t_req;

    typedef enum logic [2:0] {
        ST_KEPT     = 3'd0,
        ST_REJECTED = 3'd1,
        ST_OVERFLOW = 3'd2,
        ST_ENTRY    = 3'd3,
        ST_EMPTY    = 3'd4,
        ST_CLEARED  = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        CFG_SEARCH_MODE      = 3'd0,
        CFG_KEEP_COUNT       = 3'd1,
        CFG_RADIUS_MINUS_ONE = 3'd2,
        CFG_THRESHOLD_ENABLE = 3'd3,
        CFG_THRESHOLD_M1     = 3'd4,
        CFG_REORDER_ENABLE   = 3'd5,
        CFG_FILTER_ENABLE    = 3'd6,
        CFG_ID_OFFSET        = 3'd7
    } t_cfg_index;

    typedef enum logic [3:0] {
        S_IDLE,
        S_OFFER_CHK,
        S_UP_RD,
        S_UP_CMP,
        S_DN_RD,
        S_DN_CMP,
        S_POP_RD,
        S_POP_OUT,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic [1:0]         req_type;
        logic signed [31:0] distance;
        logic [15:0]        cand_id;
        logic               filter_ok;
    } t_in_item;

    typedef struct packed {
        logic [2:0]         status;
        logic signed [31:0] out_distance;
        logic [31:0]        out_id;
        logic [6:0]         fill_level;
        logic               last;
        logic               overflowed;
    } t_out_item;

    typedef struct packed {
        logic               search_mode;
        logic [6:0]         keep_count;
        logic signed [31:0] radius_minus_one;
        logic               threshold_enable;
        logic signed [31:0] threshold_minus_one;
        logic               reorder_enable;
        logic               filter_enable;
        logic [31:0]        id_offset;
    } t_cfg;

    typedef struct packed {
        logic start;
        logic out_free;
    } t_eng_ctl;

    typedef struct packed {
        logic busy;
        logic res_load;
    } t_eng_stat;

    // distance goes to the high word with its sign bit flipped so keys order unsigned
    function automatic t_key make_key(logic [31:0] dist_bits, logic [31:0] id);
        return {dist_bits ^ 32'h8000_0000, id};
    endfunction

    function automatic logic [31:0] key_dist(t_key key);
        return key[63:32] ^ 32'h8000_0000;
    endfunction

endpackage

// ----- hdl/topk_candidate_heap.sv -----
// topk_candidate_heap: top level with configuration registers and result register
// depends on tkh_pkg and tkh_engine
//
// keeps the best candidates in a max-heap of (distance, id) keys held in a
// 64-entry memory. in nearest-k mode an offer either fills the heap (negative
// distances only) or replaces the current largest key; in range mode nonzero
// distances below the radius are collected and the overflow flag sticks
// once the store is full. one request is worked on at a time: the input stalls
// from the cycle after a transfer until the request's last result is loaded
// into the output register, which then holds it while the next request is
// already taken; a drain cut off at the result limit also stays busy while its
// refill key sifts down. each heap level takes a read state and then a
// compare-and-write state on the memory port pair. a drain pops one key at a
// time, largest first, up to 64 results per request; a stalled result holds
// the engine until it transfers. no clearing pass: entries are only read below
// the fill count.
module topk_candidate_heap
    import tkh_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_in_valid,
    input  t_in_item    i_in_item,
    output logic        o_in_stall,
    // result channel
    output logic        o_out_valid,
    output t_out_item   o_out_item,
    input  logic        i_out_stall,
    // configuration write channel
    input  logic        i_cfg_valid,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output logic        o_cfg_ready
);

    t_cfg      r_cfg;
    logic      r_out_valid;
    t_out_item r_out_item;
    t_eng_ctl  eng_ctl;
    t_eng_stat eng_stat;
    t_out_item eng_res;

    // config writes are always taken; software must write only while the block is idle (not enforced)
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{keep_count: 7'd10, default: '0};
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_SEARCH_MODE:      r_cfg.search_mode         <= i_cfg_data[0];
                CFG_KEEP_COUNT:       r_cfg.keep_count          <= i_cfg_data[6:0];
                CFG_RADIUS_MINUS_ONE: r_cfg.radius_minus_one    <= $signed(i_cfg_data);
                CFG_THRESHOLD_ENABLE: r_cfg.threshold_enable    <= i_cfg_data[0];
                CFG_THRESHOLD_M1:     r_cfg.threshold_minus_one <= $signed(i_cfg_data);
                CFG_REORDER_ENABLE:   r_cfg.reorder_enable      <= i_cfg_data[0];
                CFG_FILTER_ENABLE:    r_cfg.filter_enable       <= i_cfg_data[0];
                CFG_ID_OFFSET:        r_cfg.id_offset           <= i_cfg_data;
                default:              r_cfg                     <= r_cfg;
            endcase
        end
    end

    // the engine is busy from the transfer until its last result is loaded and any refill sift after it ends
    assign o_in_stall       = eng_stat.busy;
    assign eng_ctl.start    = i_in_valid && !eng_stat.busy;
    // output register frees up in the same cycle its result transfers
    assign eng_ctl.out_free = !r_out_valid || !i_out_stall;

    tkh_engine u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (eng_ctl),
        .i_item  (i_in_item),
        .i_cfg   (r_cfg),
        .o_stat  (eng_stat),
        .o_res   (eng_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (eng_stat.res_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (eng_stat.res_load) begin
            r_out_item <= eng_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

// ----- hdl/tkh_engine.sv -----
// tkh_engine: heap memory and the sequencer that sifts keys through it
// depends on tkh_pkg
module tkh_engine
    import tkh_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_eng_ctl  i_ctl,
    input  t_in_item  i_item,
    input  t_cfg      i_cfg,
    output t_eng_stat o_stat,
    output t_out_item o_res
);

    t_state             r_state, n_state;
    t_fill              r_fill, n_fill;
    logic               r_ovf, n_ovf;
    t_key               r_key, n_key;
    logic signed [31:0] r_dist, n_dist;
    logic               r_fok, n_fok;
    t_req               r_req, n_req;
    t_status            r_status, n_status;
    t_addr              r_pos, n_pos;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               r_drain_end, n_drain_end;

    t_key r_mem [HEAP_DEPTH];
    t_key r_rd_a, r_rd_b;
    t_addr ra_a, ra_b, wa;
    t_key  wd;
    logic  we;

    logic [31:0]        new_id;
    logic signed [31:0] top_dist;
    logic [CMP_W-1:0]   kc, k_eff, fill_c;
    logic               filter_bad;
    logic [IDX_W-1:0]   lft, rgt, fill_x;
    t_addr              parent;
    logic               use_b;
    t_key               child;
    t_addr              cpos;
    t_fill              fill_dec;
    logic               end_now;

    always_comb begin
        new_id     = 32'(i_item.cand_id) + i_cfg.id_offset;
        top_dist   = $signed(key_dist(r_rd_a));
        filter_bad = i_cfg.filter_enable && !r_fok;
        kc         = CMP_W'(i_cfg.keep_count);
        if (kc == '0) begin
            k_eff = CMP_W'(1);
        end else if (kc > CMP_W'(HEAP_DEPTH)) begin
            k_eff = CMP_W'(HEAP_DEPTH);
        end else begin
            k_eff = kc;
        end
        fill_c   = CMP_W'(r_fill);
        fill_x   = IDX_W'(r_fill);
        lft      = {1'b0, r_pos, 1'b1};
        rgt      = lft + IDX_W'(1);
        parent   = (r_pos - ADDR_W'(1)) >> 1;
        use_b    = (rgt < fill_x) && (r_rd_b > r_rd_a);
        child    = use_b ? r_rd_b : r_rd_a;
        cpos     = use_b ? ADDR_W'(rgt) : ADDR_W'(lft);
        fill_dec = r_fill - FILL_W'(1);
        end_now  = (fill_dec == '0) || (r_cnt == CNT_W'(MAX_RESULTS - 1));
    end

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_ovf       = r_ovf;
        n_key       = r_key;
        n_dist      = r_dist;
        n_fok       = r_fok;
        n_req       = r_req;
        n_status    = r_status;
        n_pos       = r_pos;
        n_cnt       = r_cnt;
        n_drain_end = r_drain_end;
        ra_a        = '0;
        ra_b        = '0;
        we          = 1'b0;
        wa          = r_pos;
        wd          = r_key;
        o_stat.busy     = (r_state != S_IDLE);
        o_stat.res_load = 1'b0;
        o_res.status       = r_status;
        o_res.out_distance = '0;
        o_res.out_id       = '0;
        o_res.fill_level   = 7'(r_fill);
        o_res.last         = 1'b1;
        o_res.overflowed   = r_ovf;

        unique case (r_state)
            S_IDLE: begin
                // root is read here so it is ready when an offer is checked
                if (i_ctl.start) begin
                    case (i_item.req_type)
                        REQ_OFFER: begin
                            n_req   = REQ_OFFER;
                            n_dist  = i_item.distance;
                            n_fok   = i_item.filter_ok;
                            n_key   = make_key(i_item.distance, new_id);
                            n_state = S_OFFER_CHK;
                        end
                        REQ_DRAIN: begin
                            n_req       = REQ_DRAIN;
                            n_cnt       = '0;
                            n_drain_end = 1'b0;
                            if (r_fill == '0) begin
                                n_status = ST_EMPTY;
                                n_state  = S_EMIT;
                            end else begin
                                n_state = S_POP_RD;
                            end
                        end
                        REQ_CLEAR: begin
                            n_req    = REQ_CLEAR;
                            n_fill   = '0;
                            n_ovf    = 1'b0;
                            n_status = ST_CLEARED;
                            n_state  = S_EMIT;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end

            S_OFFER_CHK: begin
                n_status = ST_REJECTED;
                n_state  = S_EMIT;
                if (!i_cfg.search_mode) begin
                    if (i_cfg.threshold_enable && !i_cfg.reorder_enable
                        && r_dist > i_cfg.threshold_minus_one) begin
                        n_state = S_EMIT;
                    end else if (fill_c < k_eff) begin
                        if (!(r_dist >= 0 || filter_bad)) begin
                            n_pos   = ADDR_W'(r_fill);
                            n_fill  = r_fill + FILL_W'(1);
                            n_state = S_UP_RD;
                        end
                    end else if (fill_c == k_eff && r_dist > top_dist) begin
                        n_state = S_EMIT;
                    end else if (filter_bad || r_key > r_rd_a) begin
                        n_state = S_EMIT;
                    end else begin
                        n_pos   = '0;
                        n_state = S_DN_RD;
                    end
                end else begin
                    if (r_dist == 0 || r_dist > i_cfg.radius_minus_one || filter_bad) begin
                        n_state = S_EMIT;
                    end else if (r_fill >= FILL_W'(HEAP_DEPTH)) begin
                        n_ovf    = 1'b1;
                        n_status = ST_OVERFLOW;
                    end else begin
                        n_pos   = ADDR_W'(r_fill);
                        n_fill  = r_fill + FILL_W'(1);
                        n_state = S_UP_RD;
                    end
                end
            end

            S_UP_RD: begin
                if (r_pos == '0) begin
                    we       = 1'b1;
                    n_status = ST_KEPT;
                    n_state  = S_EMIT;
                end else begin
                    ra_a    = parent;
                    n_state = S_UP_CMP;
                end
            end

            S_UP_CMP: begin
                we = 1'b1;
                if (r_key > r_rd_a) begin
                    wd      = r_rd_a;
                    n_pos   = parent;
                    n_state = S_UP_RD;
                end else begin
                    n_status = ST_KEPT;
                    n_state  = S_EMIT;
                end
            end

            S_DN_RD: begin
                ra_a = ADDR_W'(lft);
                ra_b = ADDR_W'(rgt);
                if (lft >= fill_x) begin
                    we = 1'b1;
                    if (r_req == REQ_DRAIN) begin
                        n_state = r_drain_end ? S_IDLE : S_POP_RD;
                    end else begin
                        n_status = ST_KEPT;
                        n_state  = S_EMIT;
                    end
                end else begin
                    n_state = S_DN_CMP;
                end
            end

            S_DN_CMP: begin
                we = 1'b1;
                if (child > r_key) begin
                    wd      = child;
                    n_pos   = cpos;
                    n_state = S_DN_RD;
                end else if (r_req == REQ_DRAIN) begin
                    n_state = r_drain_end ? S_IDLE : S_POP_RD;
                end else begin
                    n_status = ST_KEPT;
                    n_state  = S_EMIT;
                end
            end

            S_POP_RD: begin
                ra_a    = '0;
                ra_b    = ADDR_W'(fill_dec);
                n_state = S_POP_OUT;
            end

            S_POP_OUT: begin
                // same addresses as the read state keep the read data steady while waiting
                ra_a = '0;
                ra_b = ADDR_W'(fill_dec);
                o_res.status       = ST_ENTRY;
                o_res.out_distance = $signed(key_dist(r_rd_a));
                o_res.out_id       = r_rd_a[31:0];
                o_res.fill_level   = 7'(fill_dec);
                o_res.last         = end_now;
                if (i_ctl.out_free) begin
                    o_stat.res_load = 1'b1;
                    n_fill          = fill_dec;
                    n_cnt           = r_cnt + CNT_W'(1);
                    n_drain_end     = end_now;
                    if (fill_dec != '0) begin
                        n_key   = r_rd_b;
                        n_pos   = '0;
                        n_state = S_DN_RD;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end

            S_EMIT: begin
                if (i_ctl.out_free) begin
                    o_stat.res_load = 1'b1;
                    n_state         = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_ovf   <= n_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key       <= n_key;
        r_dist      <= n_dist;
        r_fok       <= n_fok;
        r_req       <= n_req;
        r_status    <= n_status;
        r_pos       <= n_pos;
        r_cnt       <= n_cnt;
        r_drain_end <= n_drain_end;
    end

    // heap store: one write and two registered reads per cycle
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[wa] <= wd;
        end
        r_rd_a <= r_mem[ra_a];
        r_rd_b <= r_mem[ra_b];
    end

endmodule

// ----- hdl/tkh_checker.sv -----
// tkh_checker: port-level assertions for topk_candidate_heap, bound to the top level
// depends on tkh_pkg
module tkh_checker
    import tkh_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input t_in_item    i_in_item,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input t_out_item   o_out_item,
    input logic        i_out_stall
);

    // a held result does not change while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("result changed while stalled");

    // every known request transfer makes the block busy in the next cycle
    a_busy_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_in_item.req_type <= REQ_CLEAR |=> o_in_stall)
        else $error("request transfer did not occupy the block");

    // fill count never exceeds the store
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> int'(o_out_item.fill_level) <= HEAP_DEPTH)
        else $error("fill level above heap depth");

    // a clear leaves an empty heap and no overflow
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.status == ST_CLEARED
            |-> o_out_item.fill_level == '0 && !o_out_item.overflowed && o_out_item.last)
        else $error("clear result inconsistent");

    // only drained entries carry a payload
    a_zero_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.status != ST_ENTRY
            |-> o_out_item.out_distance == '0 && o_out_item.out_id == '0
                && o_out_item.last)
        else $error("non-entry result carries a payload");

endmodule

bind topk_candidate_heap tkh_checker u_tkh_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_item   (i_in_item),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .o_out_item  (o_out_item),
    .i_out_stall (i_out_stall)
);
